// ----- sv/wcts_pkg.sv -----
// shared types and constants of the weighted class transmit scheduler
`timescale 1ns / 1ps

package wcts_pkg;

  // payload field widths
  localparam int FUNC_W   = 3;
  localparam int CLASS_W  = 3;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;

  // scheduler state widths
  localparam int ACC_W    = 18;
  localparam int WEIGHT_W = 8;
  localparam int WRAP_W   = 10;

  // configuration port
  localparam int CFG_AW   = 5;
  localparam int CFG_DW   = 32;
  localparam int NUM_WREGS = 5;

  // register indexes
  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_W0   = 3'd1;
  localparam logic [2:0] REG_W1   = 3'd2;
  localparam logic [2:0] REG_W2   = 3'd3;
  localparam logic [2:0] REG_W3   = 3'd4;
  localparam logic [2:0] REG_W4   = 3'd5;
  localparam logic [2:0] REG_WRAP = 3'd6;

  // register reset values
  localparam logic                RST_MODE = 1'b1;
  localparam logic [WEIGHT_W-1:0] RST_W0   = 8'd1;
  localparam logic [WEIGHT_W-1:0] RST_W1   = 8'd1;
  localparam logic [WEIGHT_W-1:0] RST_W2   = 8'd3;
  localparam logic [WEIGHT_W-1:0] RST_W3   = 8'd12;
  localparam logic [WEIGHT_W-1:0] RST_W4   = 8'd48;
  localparam logic [WRAP_W-1:0]   RST_WRAP = 10'd200;

  // command codes
  localparam logic [FUNC_W-1:0] FN_ENQ     = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ     = 3'd1;
  localparam logic [FUNC_W-1:0] FN_DONE    = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RESCAN  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CHANGED = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DROP    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // class selection handed from the arbiter
  typedef struct packed {
    logic               chosen;
    logic [CLASS_W-1:0] cls;
  } pick_t;

endpackage

// ----- sv/wcts_in_if.sv -----
// command channel of the scheduler
`timescale 1ns / 1ps

interface wcts_in_if import wcts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [CLASS_W-1:0]  msg_class;
  logic [TAG_W-1:0]    msg_tag;
  logic                new_transfer;

  modport source (output valid, func, msg_class, msg_tag, new_transfer, input ready);
  modport sink   (input valid, func, msg_class, msg_tag, new_transfer, output ready);
endinterface

// ----- sv/wcts_out_if.sv -----
// result channel of the scheduler
`timescale 1ns / 1ps

interface wcts_out_if import wcts_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                grant_valid;
  logic                class_chosen;
  logic [CLASS_W-1:0]  grant_class;
  logic [TAG_W-1:0]    grant_tag;
  logic [STATUS_W-1:0] status;
  logic [TOTAL_W-1:0]  outstanding_total;

  modport source (output valid, grant_valid, class_chosen, grant_class, grant_tag, status,
                  outstanding_total, input ready);
  modport sink   (input valid, grant_valid, class_chosen, grant_class, grant_tag, status,
                  outstanding_total, output ready);
endinterface

// ----- sv/weighted_class_tx_scheduler_unit.sv -----
// top level of the weighted class transmit scheduler
//
//   channel   direction  handshake          word
//   in_if     in         valid/ready        func, msg_class, msg_tag, new_transfer
//   out_if    out        valid/ready        grant and status fields, outstanding_total
//   cfg_*     in         apb write / read   weight_mode, weight_class0..4, wrap_limit
//
// One command is taken per cycle unless out_if.ready holds the result stage.
// All per-class counters, the arbiter and the weight update settle in the accept
// cycle; the tag memory has one write and one read port, read data registered.
// A result stage and an output register follow, so one more command is taken
// while a result waits on out_if.ready. Reset is synchronous, active low, and
// clears all counters; the tag memory is not cleared and needs no sweep.
`timescale 1ns / 1ps

module weighted_class_tx_scheduler_unit import wcts_pkg::*; #(
  parameter int FIFO_DEPTH  = 16,
  parameter int NUM_CLASSES = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  wcts_in_if.sink            in_if,
  wcts_out_if.source         out_if,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int STICKY_W  = $clog2(NUM_CLASSES + 1);
  localparam int CIDX_W    = $clog2(NUM_CLASSES);
  localparam int MEM_DEPTH = NUM_CLASSES * FIFO_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int TOT_W     = $clog2(MEM_DEPTH + 1);

  localparam logic [STICKY_W-1:0] STICKY_NONE = STICKY_W'(NUM_CLASSES);
  localparam logic [CLASS_W:0]    NCLS        = (CLASS_W + 1)'(NUM_CLASSES);
  localparam logic [CNT_W-1:0]    DEPTH_CNT   = CNT_W'(FIFO_DEPTH);
  localparam logic [PTR_W-1:0]    LAST_SLOT   = PTR_W'(FIFO_DEPTH - 1);

  // configuration registers
  logic                mode_r;
  logic [WEIGHT_W-1:0] wreg_r [NUM_WREGS];
  logic [WRAP_W-1:0]   wrap_r;
  logic                cfg_we;

  // per-class queue and scheduling state
  logic [PTR_W-1:0] head_r    [NUM_CLASSES];
  logic [PTR_W-1:0] head_nxt  [NUM_CLASSES];
  logic [PTR_W-1:0] tail_r    [NUM_CLASSES];
  logic [PTR_W-1:0] tail_nxt  [NUM_CLASSES];
  logic [CNT_W-1:0] fill_r    [NUM_CLASSES];
  logic [CNT_W-1:0] fill_nxt  [NUM_CLASSES];
  logic [CNT_W-1:0] wait_r    [NUM_CLASSES];
  logic [CNT_W-1:0] wait_nxt  [NUM_CLASSES];
  logic [CNT_W-1:0] outst_r   [NUM_CLASSES];
  logic [CNT_W-1:0] outst_nxt [NUM_CLASSES];
  logic [NUM_CLASSES-1:0][ACC_W-1:0] acc_r;
  logic [NUM_CLASSES-1:0][ACC_W-1:0] acc_nxt;
  logic [WRAP_W-1:0]   pick_r;
  logic [WRAP_W-1:0]   pick_nxt;
  logic                change_r;
  logic                change_nxt;
  logic [STICKY_W-1:0] sticky_r;
  logic [STICKY_W-1:0] sticky_nxt;

  // command decode and arbitration
  logic                          accept;
  logic                          cls_ok;
  logic [CIDX_W-1:0]             cidx;
  logic [CIDX_W-1:0]             jidx;
  logic [NUM_CLASSES-1:0]        busy;
  logic [NUM_CLASSES-1:0][WEIGHT_W-1:0] wvec;
  pick_t                         pick;
  logic                          gvalid;
  logic [STATUS_W-1:0]           status;
  logic [TOT_W-1:0]              tot_sum;

  // tag memory
  logic [TAG_W-1:0]  tag_mem [MEM_DEPTH];
  logic [TAG_W-1:0]  mem_q_r;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;

  // result stage and output register
  logic                s1_v_r;
  logic                s1_gvalid_r;
  logic                s1_chosen_r;
  logic [CLASS_W-1:0]  s1_class_r;
  logic [STATUS_W-1:0] s1_status_r;
  logic [TOTAL_W-1:0]  s1_total_r;
  logic                s1_move;
  logic                s2_v_r;
  logic                s2_gvalid_r;
  logic                s2_chosen_r;
  logic [CLASS_W-1:0]  s2_class_r;
  logic [TAG_W-1:0]    s2_tag_r;
  logic [STATUS_W-1:0] s2_status_r;
  logic [TOTAL_W-1:0]  s2_total_r;

  // apb register port
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= RST_MODE;
      wreg_r[0] <= RST_W0;
      wreg_r[1] <= RST_W1;
      wreg_r[2] <= RST_W2;
      wreg_r[3] <= RST_W3;
      wreg_r[4] <= RST_W4;
      wrap_r    <= RST_WRAP;
    end else if (cfg_we) begin
      case (cfg_paddr[4:2])
        REG_MODE: mode_r    <= cfg_pwdata[0];
        REG_W0:   wreg_r[0] <= cfg_pwdata[WEIGHT_W-1:0];
        REG_W1:   wreg_r[1] <= cfg_pwdata[WEIGHT_W-1:0];
        REG_W2:   wreg_r[2] <= cfg_pwdata[WEIGHT_W-1:0];
        REG_W3:   wreg_r[3] <= cfg_pwdata[WEIGHT_W-1:0];
        REG_W4:   wreg_r[4] <= cfg_pwdata[WEIGHT_W-1:0];
        REG_WRAP: wrap_r    <= cfg_pwdata[WRAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_MODE: cfg_prdata = CFG_DW'(mode_r);
      REG_W0:   cfg_prdata = CFG_DW'(wreg_r[0]);
      REG_W1:   cfg_prdata = CFG_DW'(wreg_r[1]);
      REG_W2:   cfg_prdata = CFG_DW'(wreg_r[2]);
      REG_W3:   cfg_prdata = CFG_DW'(wreg_r[3]);
      REG_W4:   cfg_prdata = CFG_DW'(wreg_r[4]);
      REG_WRAP: cfg_prdata = CFG_DW'(wrap_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // per-class weight, one when mode_r is clear and for classes past the weight registers
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_wvec
    if (c < NUM_WREGS) begin : g_reg
      assign wvec[c] = mode_r ? wreg_r[c] : WEIGHT_W'(1);
    end else begin : g_one
      assign wvec[c] = WEIGHT_W'(1);
    end
    assign busy[c] = (outst_r[c] != '0);
  end

  // handshake: a command enters when the result stage is free or draining
  assign s1_move     = s1_v_r & (~s2_v_r | out_if.ready);
  assign in_if.ready = ~s1_v_r | s1_move;
  assign accept      = in_if.valid & in_if.ready;

  assign cls_ok = ({1'b0, in_if.msg_class} < NCLS);
  assign cidx   = in_if.msg_class[CIDX_W-1:0];
  assign jidx   = pick.cls[CIDX_W-1:0];

  wcts_arb #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_arb (
    .busy         (busy),
    .acc          (acc_r),
    .sticky       (sticky_r),
    .new_transfer (in_if.new_transfer),
    .pick         (pick)
  );

  // read-modify-write of the class state for one command
  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    fill_nxt   = fill_r;
    wait_nxt   = wait_r;
    outst_nxt  = outst_r;
    acc_nxt    = acc_r;
    pick_nxt   = pick_r;
    change_nxt = change_r;
    sticky_nxt = sticky_r;
    gvalid     = 1'b0;
    status     = ST_OK;
    mem_we     = 1'b0;
    wr_addr    = ADDR_W'(cidx * FIFO_DEPTH) + ADDR_W'(tail_r[cidx]);
    rd_addr    = ADDR_W'(jidx * FIFO_DEPTH) + ADDR_W'(head_r[jidx]);
    case (in_if.func)
      FN_ENQ: begin
        if (!cls_ok || fill_r[cidx] >= DEPTH_CNT) begin
          status = ST_DROP;
        end else begin
          mem_we         = 1'b1;
          tail_nxt[cidx] = (tail_r[cidx] == LAST_SLOT) ? '0 : tail_r[cidx] + 1'b1;
          fill_nxt[cidx] = fill_r[cidx] + 1'b1;
          wait_nxt[cidx] = wait_r[cidx] + 1'b1;
        end
      end
      FN_DEQ: begin
        if (in_if.new_transfer) begin
          sticky_nxt = STICKY_NONE;
        end
        if (pick.chosen) begin
          sticky_nxt    = STICKY_W'(pick.cls);
          acc_nxt[jidx] = acc_r[jidx] + ACC_W'(wvec[jidx]);
          if (pick_r >= wrap_r || change_r) begin
            acc_nxt    = '0;
            pick_nxt   = '0;
            change_nxt = 1'b0;
          end else begin
            pick_nxt = pick_r + 1'b1;
          end
          if (fill_r[jidx] > wait_r[jidx]) begin
            gvalid         = 1'b1;
            head_nxt[jidx] = (head_r[jidx] == LAST_SLOT) ? '0 : head_r[jidx] + 1'b1;
            fill_nxt[jidx] = fill_r[jidx] - 1'b1;
          end
        end
      end
      FN_DONE: begin
        if (!cls_ok || outst_r[cidx] == '0) begin
          status = ST_IGNORED;
        end else begin
          outst_nxt[cidx] = outst_r[cidx] - 1'b1;
        end
      end
      FN_RESCAN: begin
        // admit every waiting tag once nothing is outstanding
        if (busy == '0) begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            outst_nxt[c] = wait_r[c];
            wait_nxt[c]  = '0;
          end
        end
      end
      FN_CHANGED: change_nxt = 1'b1;
      default: ;
    endcase
  end

  // outstanding total after the command
  always_comb begin
    tot_sum = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      tot_sum = tot_sum + TOT_W'(outst_nxt[c]);
    end
  end

  // class state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_r[c]  <= '0;
        tail_r[c]  <= '0;
        fill_r[c]  <= '0;
        wait_r[c]  <= '0;
        outst_r[c] <= '0;
      end
      acc_r    <= '0;
      pick_r   <= '0;
      change_r <= 1'b0;
      sticky_r <= STICKY_NONE;
    end else if (accept) begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      fill_r   <= fill_nxt;
      wait_r   <= wait_nxt;
      outst_r  <= outst_nxt;
      acc_r    <= acc_nxt;
      pick_r   <= pick_nxt;
      change_r <= change_nxt;
      sticky_r <= sticky_nxt;
    end
  end

  // tag memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      tag_mem[wr_addr] <= in_if.msg_tag;
    end
    if (accept) begin
      mem_q_r <= tag_mem[rd_addr];
    end
  end

  // result stage, lines up with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_move) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_gvalid_r <= (in_if.func == FN_DEQ) & gvalid;
      s1_chosen_r <= (in_if.func == FN_DEQ) & pick.chosen;
      s1_class_r  <= ((in_if.func == FN_DEQ) && pick.chosen) ? pick.cls : '0;
      s1_status_r <= status;
      s1_total_r  <= TOTAL_W'(tot_sum);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_move) begin
      s2_v_r <= 1'b1;
    end else if (out_if.ready) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_gvalid_r <= s1_gvalid_r;
      s2_chosen_r <= s1_chosen_r;
      s2_class_r  <= s1_class_r;
      s2_tag_r    <= s1_gvalid_r ? mem_q_r : '0;
      s2_status_r <= s1_status_r;
      s2_total_r  <= s1_total_r;
    end
  end

  assign out_if.valid             = s2_v_r;
  assign out_if.grant_valid       = s2_gvalid_r;
  assign out_if.class_chosen      = s2_chosen_r;
  assign out_if.grant_class       = s2_class_r;
  assign out_if.grant_tag         = s2_tag_r;
  assign out_if.status            = s2_status_r;
  assign out_if.outstanding_total = s2_total_r;

`ifndef ASSERT_OFF
  // a handed-out tag always comes with a selected class
  a_grant_has_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.grant_valid |-> out_if.class_chosen)
    else $error("grant without a chosen class");

  // a chosen class becomes the sticky class
  a_sticky_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && s1_chosen_r |-> sticky_r == STICKY_W'(s1_class_r))
    else $error("sticky class does not follow the pick");

  // waiting tags are always held in their fifo
  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_chk
    a_wait_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
      wait_r[c] <= fill_r[c])
      else $error("more waiting tags than fifo entries");
  end
`endif

endmodule

// ----- sv/wcts_arb.sv -----
// class arbiter: sticky class or least accumulated weight among busy classes
`timescale 1ns / 1ps

module wcts_arb import wcts_pkg::*; #(
  parameter int NUM_CLASSES = 5
) (
  input  logic [NUM_CLASSES-1:0]            busy,
  input  logic [NUM_CLASSES-1:0][ACC_W-1:0] acc,
  input  logic [$clog2(NUM_CLASSES+1)-1:0]  sticky,
  input  logic                              new_transfer,
  output pick_t                             pick
);

  localparam int STICKY_W = $clog2(NUM_CLASSES + 1);

  logic               stay;
  logic               found;
  logic [CLASS_W-1:0] best;
  logic [ACC_W-1:0]   best_acc;

  // sticky hit, else lowest weight with lowest index on a tie
  always_comb begin
    stay     = 1'b0;
    found    = 1'b0;
    best     = '0;
    best_acc = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!new_transfer && sticky == STICKY_W'(c) && busy[c]) begin
        stay = 1'b1;
      end
      if (busy[c] && (!found || acc[c] < best_acc)) begin
        found    = 1'b1;
        best     = CLASS_W'(c);
        best_acc = acc[c];
      end
    end
    pick.chosen = stay | found;
    pick.cls    = stay ? CLASS_W'(sticky) : best;
  end

endmodule

// ----- sim/tb_weighted_class_tx_scheduler_unit.sv -----
// self-checking testbench of the weighted class transmit scheduler
`timescale 1ns / 1ps

module tb_weighted_class_tx_scheduler_unit;
  import wcts_pkg::*;

  localparam int NCLS        = 5;
  localparam int DEPTH       = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int SHOWN       = 10;

  // command code the block does not decode
  localparam logic [FUNC_W-1:0] FN_SPARE = 3'd7;

  typedef struct packed {
    logic                grant_valid;
    logic                class_chosen;
    logic [CLASS_W-1:0]  grant_class;
    logic [TAG_W-1:0]    grant_tag;
    logic [STATUS_W-1:0] status;
    logic [TOTAL_W-1:0]  outstanding_total;
  } grant_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  wcts_in_if  cmd_ch ();
  wcts_out_if grant_ch ();

  // scheduler settings as last written
  logic                mode_m = RST_MODE;
  logic [WEIGHT_W-1:0] weight_m[NCLS] = '{RST_W0, RST_W1, RST_W2, RST_W3, RST_W4};
  logic [WRAP_W-1:0]   wrap_m = RST_WRAP;

  // mirrored class queues, counters and arbiter state
  logic [TAG_W-1:0]  tag_mem[NCLS][DEPTH];
  int                q_head[NCLS] = '{default: 0};
  int                q_tail[NCLS] = '{default: 0};
  int                q_fill[NCLS] = '{default: 0};
  int                q_wait[NCLS] = '{default: 0};
  int                q_out[NCLS]  = '{default: 0};
  logic [ACC_W-1:0]  acc_wt[NCLS] = '{default: '0};
  logic [WRAP_W-1:0] pick_count   = '0;
  logic              change_seen  = 1'b0;
  int                sticky       = NCLS;

  grant_t expected_grants[$];
  grant_t seen_grant;
  grant_t due_grant;

  int idle_pct         = 0;
  int stall_pct        = 0;
  int useful_cmds      = 0;
  int settings_applied = 0;
  int mismatches       = 0;
  int quiet_cycles     = 0;
  int n_grants         = 0;
  int n_empty          = 0;
  int n_drops          = 0;
  int n_ignored        = 0;

  weighted_class_tx_scheduler_unit #(
    .FIFO_DEPTH  (DEPTH),
    .NUM_CLASSES (NCLS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (cmd_ch),
    .out_if      (grant_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int outstanding_sum();
    int s;
    s = 0;
    for (int k = 0; k < NCLS; k++) s += q_out[k];
    return s;
  endfunction

  // mostly valid classes, now and then one out of range, from NCLS to 7
  function automatic logic [CLASS_W-1:0] pick_class();
    if ($urandom_range(99) < 8) return CLASS_W'($urandom_range(7, NCLS));
    return CLASS_W'($urandom_range(NCLS - 1));
  endfunction

  // advance the mirrored scheduler by one command and queue the word it must return
  task automatic schedule_command(input logic [FUNC_W-1:0] f, input logic [CLASS_W-1:0] c,
                                  input logic [TAG_W-1:0] t, input logic nt);
    grant_t g;
    int     j;
    int     k;
    g = '0;
    j = NCLS;
    case (f)
      FN_ENQ: begin
        if (c >= NCLS || q_fill[c] >= DEPTH) begin
          g.status = ST_DROP;
          n_drops++;
        end else begin
          tag_mem[c][q_tail[c]] = t;
          q_tail[c] = (q_tail[c] + 1) % DEPTH;
          q_fill[c]++;
          q_wait[c]++;
        end
      end
      FN_DEQ: begin
        if (nt) sticky = NCLS;
        // stay on the sticky class, else least accumulated weight, lowest index wins
        if (sticky < NCLS && q_out[sticky] != 0) begin
          j = sticky;
        end else begin
          for (k = 0; k < NCLS; k++)
            if (q_out[k] != 0 && (j == NCLS || acc_wt[k] < acc_wt[j])) j = k;
          if (j < NCLS) sticky = j;
        end
        if (j < NCLS) begin
          g.class_chosen = 1'b1;
          g.grant_class  = CLASS_W'(j);
          acc_wt[j] = acc_wt[j] + (mode_m ? weight_m[j] : 8'd1);
          if (pick_count >= wrap_m || change_seen) begin
            for (k = 0; k < NCLS; k++) acc_wt[k] = '0;
            pick_count  = '0;
            change_seen = 1'b0;
          end else begin
            pick_count = pick_count + 1'b1;
          end
          // only admitted tags can leave
          if (q_fill[j] > q_wait[j]) begin
            g.grant_valid = 1'b1;
            g.grant_tag   = tag_mem[j][q_head[j]];
            q_head[j] = (q_head[j] + 1) % DEPTH;
            q_fill[j]--;
            n_grants++;
          end else begin
            n_empty++;
          end
        end
      end
      FN_DONE: begin
        if (c >= NCLS || q_out[c] == 0) begin
          g.status = ST_IGNORED;
          n_ignored++;
        end else begin
          q_out[c]--;
        end
      end
      FN_RESCAN: begin
        if (outstanding_sum() == 0)
          for (k = 0; k < NCLS; k++) begin
            q_out[k] += q_wait[k];
            q_wait[k] = 0;
          end
      end
      FN_CHANGED: change_seen = 1'b1;
      default: ;
    endcase
    g.outstanding_total = TOTAL_W'(outstanding_sum());
    expected_grants.push_back(g);
  endtask

  // present one command word, with random idle cycles ahead of it
  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [CLASS_W-1:0] c,
                          input logic [TAG_W-1:0] t, input logic nt);
    while ($urandom_range(99) < idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.func         <= f;
    cmd_ch.msg_class    <= c;
    cmd_ch.msg_tag      <= t;
    cmd_ch.new_transfer <= nt;
    do @(posedge clk); while (!cmd_ch.ready);
    schedule_command(f, c, t, nt);
    if (f <= FN_CHANGED) useful_cmds++;
  endtask

  // stop sending and let every due word come back
  task automatic wait_drain();
    cmd_ch.valid <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // apb write: setup, access, then idle with psel low
  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE: mode_m = val[0];
      REG_WRAP: wrap_m = val[WRAP_W-1:0];
      default:  weight_m[idx - REG_W0] = val[WEIGHT_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic mode, input logic [WEIGHT_W-1:0] w0, w1, w2, w3, w4,
                               input logic [WRAP_W-1:0] wrap);
    wait_drain();
    write_reg(REG_MODE, CFG_DW'(mode));
    write_reg(REG_W0, CFG_DW'(w0));
    write_reg(REG_W1, CFG_DW'(w1));
    write_reg(REG_W2, CFG_DW'(w2));
    write_reg(REG_W3, CFG_DW'(w3));
    write_reg(REG_W4, CFG_DW'(w4));
    write_reg(REG_WRAP, CFG_DW'(wrap));
    settings_applied++;
  endtask

  // random traffic, mostly enqueue bursts, a rescan and a drain by dequeue and completion
  task automatic run_traffic(input int n);
    int                 goal;
    int                 r;
    logic [CLASS_W-1:0] c;
    goal = useful_cmds + n;
    while (useful_cmds < goal) begin
      r = $urandom_range(99);
      if (r < 12) begin
        // flood one class up to or past its depth
        c = CLASS_W'($urandom_range(NCLS - 1));
        repeat ($urandom_range(DEPTH - 2, DEPTH + 4))
          send_cmd(FN_ENQ, c, TAG_W'($urandom), 1'($urandom));
      end else if (r < 22) begin
        // any field value at all
        send_cmd(FUNC_W'($urandom), CLASS_W'($urandom), TAG_W'($urandom), 1'($urandom));
      end else begin
        if (outstanding_sum() == 0) begin
          repeat ($urandom_range(1, 12))
            send_cmd(FN_ENQ, pick_class(), TAG_W'($urandom), 1'($urandom));
          send_cmd(FN_RESCAN, pick_class(), TAG_W'($urandom), 1'($urandom));
        end
        while (outstanding_sum() != 0 && useful_cmds < goal) begin
          r = $urandom_range(99);
          if (r < 50) begin
            send_cmd(FN_DEQ, CLASS_W'($urandom), TAG_W'($urandom), $urandom_range(99) < 20);
          end else if (r < 85) begin
            do c = CLASS_W'($urandom_range(NCLS - 1)); while (q_out[c] == 0);
            send_cmd(FN_DONE, c, TAG_W'($urandom), 1'($urandom));
          end else begin
            send_cmd(FUNC_W'($urandom_range(FN_ENQ, FN_CHANGED)), pick_class(),
                     TAG_W'($urandom), 1'($urandom));
          end
        end
      end
    end
  endtask

  // reset weights: corner commands and a short admitted batch
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    // completion at zero, then one with a class out of range
    send_cmd(FN_DONE, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_DONE, 3'd7, 8'hFF, 1'b1);
    // enqueue with a class out of range is dropped
    send_cmd(FN_ENQ, 3'd5, 8'h55, 1'b0);
    // dequeue with nothing outstanding, then an undecoded code
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_SPARE, 3'd7, 8'hFF, 1'b1);
    send_cmd(FN_ENQ, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_ENQ, 3'd1, 8'hFF, 1'b1);
    send_cmd(FN_ENQ, 3'd2, 8'hAA, 1'b0);
    send_cmd(FN_ENQ, 3'd3, 8'h01, 1'b0);
    send_cmd(FN_ENQ, 3'd4, 8'h80, 1'b0);
    send_cmd(FN_ENQ, 3'd2, 8'h7F, 1'b0);
    send_cmd(FN_RESCAN, 3'd0, 8'h00, 1'b0);
    // this tag waits: the rescan after it finds work outstanding
    send_cmd(FN_ENQ, 3'd4, 8'h33, 1'b0);
    send_cmd(FN_RESCAN, 3'd0, 8'h00, 1'b0);
    // second pick stays sticky on a class with no tag left
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b1);
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_DONE, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_DONE, 3'd1, 8'h00, 1'b0);
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b1);
    // weights changed: the next pick clears the accumulated weights
    send_cmd(FN_CHANGED, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b1);
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b1);
    send_cmd(FN_DONE, 3'd2, 8'h00, 1'b0);
    send_cmd(FN_DONE, 3'd3, 8'h00, 1'b0);
    send_cmd(FN_DONE, 3'd4, 8'h00, 1'b0);
    send_cmd(FN_RESCAN, 3'd0, 8'h00, 1'b0);
    send_cmd(FN_DEQ, 3'd0, 8'h00, 1'b0);
  endtask

  // every class weighs one, weights cleared every fourth pick
  task automatic test_equal_weights();
    apply_setting(1'b0, 8'd7, 8'd200, 8'd1, 8'd255, 8'd50, 10'd3);
    idle_pct  = 83;
    stall_pct = 0;
    run_traffic(140);
  endtask

  // extreme weights, cleared on every pick
  task automatic test_extreme_weights();
    apply_setting(1'b1, 8'd255, 8'd1, 8'd255, 8'd1, 8'd128, 10'd0);
    idle_pct  = 0;
    stall_pct = 83;
    run_traffic(140);
  endtask

  // random weights, longest wrap
  task automatic test_random_weights();
    apply_setting(1'b1, 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                  8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                  8'($urandom_range(1, 255)), 10'd1023);
    idle_pct  = 33;
    stall_pct = 33;
    run_traffic(140);
  endtask

  // small weights with a short random wrap
  task automatic test_short_wrap();
    apply_setting(1'b1, 8'd2, 8'd1, 8'd1, 8'd3, 8'd1, 10'($urandom_range(1, 8)));
    idle_pct  = 0;
    stall_pct = 0;
    run_traffic(140);
  endtask

  // back to the power-on values
  task automatic test_restored_defaults();
    apply_setting(RST_MODE, RST_W0, RST_W1, RST_W2, RST_W3, RST_W4, RST_WRAP);
    idle_pct  = 33;
    stall_pct = 33;
    run_traffic(140);
  endtask

  // result sink stalls at random
  always @(posedge clk) begin
    grant_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each result word with the oldest one due
  always @(posedge clk) begin
    if (rst_n && grant_ch.valid && grant_ch.ready) begin
      seen_grant = {grant_ch.grant_valid, grant_ch.class_chosen, grant_ch.grant_class,
                    grant_ch.grant_tag, grant_ch.status, grant_ch.outstanding_total};
      if (expected_grants.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN)
          $display("%0t: word with none due: gv=%0b ch=%0b cls=%0d tag=%02h st=%0d tot=%0d",
                   $time, seen_grant.grant_valid, seen_grant.class_chosen,
                   seen_grant.grant_class, seen_grant.grant_tag, seen_grant.status,
                   seen_grant.outstanding_total);
      end else begin
        due_grant = expected_grants.pop_front();
        if (seen_grant !== due_grant) begin
          mismatches++;
          if (mismatches <= SHOWN) begin
            $display("%0t: mismatch: expected gv=%0b ch=%0b cls=%0d tag=%02h st=%0d tot=%0d",
                     $time, due_grant.grant_valid, due_grant.class_chosen,
                     due_grant.grant_class, due_grant.grant_tag, due_grant.status,
                     due_grant.outstanding_total);
            $display("%0t: mismatch: got      gv=%0b ch=%0b cls=%0d tag=%02h st=%0d tot=%0d",
                     $time, seen_grant.grant_valid, seen_grant.class_chosen,
                     seen_grant.grant_class, seen_grant.grant_tag, seen_grant.status,
                     seen_grant.outstanding_total);
          end
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (grant_ch.valid && grant_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stalled for %0d cycles with %0d words still due", quiet_cycles,
               expected_grants.size());
      $display("tb_weighted_class_tx_scheduler_unit NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cmd_ch.valid        <= 1'b0;
    cmd_ch.func         <= FN_ENQ;
    cmd_ch.msg_class    <= '0;
    cmd_ch.msg_tag      <= '0;
    cmd_ch.new_transfer <= 1'b0;
    cfg_psel            <= 1'b0;
    cfg_penable         <= 1'b0;
    cfg_pwrite          <= 1'b0;
    cfg_paddr           <= '0;
    cfg_pwdata          <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_equal_weights();
    test_extreme_weights();
    test_random_weights();
    test_short_wrap();
    test_restored_defaults();
    wait_drain();

    $display("covered %0d commands under %0d weight settings and four pacing mixes",
             useful_cmds, settings_applied + 1);
    $display("%0d tags granted, %0d picks without a tag, %0d drops, %0d ignored, %0d mismatches",
             n_grants, n_empty, n_drops, n_ignored, mismatches);
    if (mismatches == 0)
      $display("tb_weighted_class_tx_scheduler_unit OK");
    else
      $display("tb_weighted_class_tx_scheduler_unit NOT OK");
    $finish;
  end

endmodule
